/* hdl/bce_pkg.sv */
// Shared widths, types and constants for the Bezier curve evaluator.
package bce_pkg;

   // Curve degree, 1 to 3
   localparam int DEGREE      = 3;
   localparam int NUM_POINTS  = DEGREE + 1;
   localparam int MAX_POINTS  = 4;

   localparam int PARAM_W     = 17;
   localparam int COORD_W     = 32;
   localparam int HALF_W      = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 2 * COORD_W;

   localparam logic [PARAM_W-1:0] PARAM_ONE = 17'h1_0000;

   // Power products t*t, t*s, s*s and the coefficient-scaled second factor
   localparam int POW_W  = 2 * PARAM_W;
   localparam int COEF_W = 2;
   localparam int BC_W   = PARAM_W + COEF_W;
   localparam int PROD_W = POW_W + BC_W;

   // Weights are unsigned Q0.(16*DEGREE), one extra bit to hold exactly one
   localparam int FRAC_W = HALF_W * DEGREE;
   localparam int WGT_W  = FRAC_W + 1;
   localparam int WLO_W  = (WGT_W + 1) / 2;
   localparam int WHI_W  = WGT_W - WLO_W;

   // Partial products, their per-kind sums and the full signed sum
   localparam int PP_W   = WLO_W + HALF_W + 2;
   localparam int GROW_W = $clog2(NUM_POINTS);
   localparam int KS_W   = PP_W + GROW_W;
   localparam int SUM_W  = WGT_W + COORD_W + 1;

   localparam logic signed [SUM_W-1:0] ROUND_HALF =
      {{(SUM_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

   localparam int NSTAGE = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POINT0_X = 4'd0,
      REG_POINT0_Y = 4'd1,
      REG_POINT1_X = 4'd2,
      REG_POINT1_Y = 4'd3,
      REG_POINT2_X = 4'd4,
      REG_POINT2_Y = 4'd5,
      REG_POINT3_X = 4'd6,
      REG_POINT3_Y = 4'd7
   } csr_reg_type;

   typedef logic [WGT_W-1:0]          wgt_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } pipe_en_type;

   // Binomial coefficient C(n,k) for n up to 3
   function automatic logic [COEF_W-1:0] binom(input int n, input int k);
      logic [COEF_W-1:0] c;
      if (k == 0 || k == n) begin
         c = COEF_W'(1);
      end else if (n == 3) begin
         c = COEF_W'(3);
      end else begin
         c = COEF_W'(2);
      end
      return c;
   endfunction

endpackage

/* hdl/bce_weights.sv */
// Bernstein weight generation: clamp, power products, scaled weights (stages 1-3).
module bce_weights
   import bce_pkg::*;
(
   input  logic                    clock,
   input  pipe_en_type             en,
   input  logic [PARAM_W-1:0]      curve_param,
   output wgt_type [NUM_POINTS-1:0] weight
);

   logic [PARAM_W-1:0] t1_ff, t1_in, s1_ff, s1_in;
   logic [PARAM_W-1:0] t2_ff, s2_ff;
   logic [POW_W-1:0]   tt2_ff, tt2_in, ts2_ff, ts2_in, ss2_ff, ss2_in;
   logic [POW_W-1:0]   fa [NUM_POINTS];
   logic [BC_W-1:0]    fb [NUM_POINTS];
   logic [PROD_W-1:0]  prod [NUM_POINTS];
   wgt_type [NUM_POINTS-1:0] w3_ff, w3_in;

   // stage 1: clamp t to one, s = 1 - t
   // stage 2: t*t, t*s, s*s
   always_comb begin
      t1_in  = (curve_param > PARAM_ONE) ? PARAM_ONE : curve_param;
      s1_in  = PARAM_ONE - t1_in;
      tt2_in = POW_W'(t1_ff) * POW_W'(t1_ff);
      ts2_in = POW_W'(t1_ff) * POW_W'(s1_ff);
      ss2_in = POW_W'(s1_ff) * POW_W'(s1_ff);
   end

   // stage 3: w_i = C(n,i) * t^i * s^(n-i) as one product of two factors
   always_comb begin
      for (int i = 0; i < NUM_POINTS; i++) begin
         if (DEGREE == 1) begin
            fa[i] = (i == 0) ? POW_W'(s2_ff) : POW_W'(t2_ff);
            fb[i] = BC_W'(1);
         end else if (DEGREE == 2) begin
            fa[i] = (i == 0) ? ss2_ff : ((i == 1) ? ts2_ff : tt2_ff);
            fb[i] = BC_W'(binom(DEGREE, i));
         end else begin
            fa[i] = (i == 0) ? ss2_ff : ((i == DEGREE) ? tt2_ff : ts2_ff);
            fb[i] = BC_W'(binom(DEGREE, i)) * BC_W'((i < 2) ? s2_ff : t2_ff);
         end
         prod[i]  = PROD_W'(fa[i]) * PROD_W'(fb[i]);
         w3_in[i] = prod[i][WGT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         t1_ff <= t1_in;
         s1_ff <= s1_in;
      end
      if (en.s2) begin
         t2_ff  <= t1_ff;
         s2_ff  <= s1_ff;
         tt2_ff <= tt2_in;
         ts2_ff <= ts2_in;
         ss2_ff <= ss2_in;
      end
      if (en.s3) begin
         w3_ff <= w3_in;
      end
   end

   assign weight = w3_ff;

endmodule

/* hdl/bce_combine.sv */
// Weighted sum of one coordinate: split products, per-kind sums, rounded total (stages 4-6).
module bce_combine
   import bce_pkg::*;
(
   input  logic                      clock,
   input  pipe_en_type               en,
   input  wgt_type [NUM_POINTS-1:0]  weight,
   input  coord_type [NUM_POINTS-1:0] point,
   output logic signed [SUM_W-1:0]   total
);

   logic signed [PP_W-1:0]  ll4_ff [NUM_POINTS], ll4_in [NUM_POINTS];
   logic signed [PP_W-1:0]  lh4_ff [NUM_POINTS], lh4_in [NUM_POINTS];
   logic signed [PP_W-1:0]  hl4_ff [NUM_POINTS], hl4_in [NUM_POINTS];
   logic signed [PP_W-1:0]  hh4_ff [NUM_POINTS], hh4_in [NUM_POINTS];
   logic signed [WLO_W:0]   wl [NUM_POINTS];
   logic signed [WHI_W:0]   wh [NUM_POINTS];
   logic signed [HALF_W:0]  pl [NUM_POINTS];
   logic signed [HALF_W-1:0] ph [NUM_POINTS];
   logic signed [KS_W-1:0]  ll5_ff, ll5_in, lh5_ff, lh5_in, hl5_ff, hl5_in, hh5_ff, hh5_in;
   logic signed [SUM_W-1:0] total6_ff, total6_in;

   // stage 4: weight = wh:wl, point = ph:pl, four partial products per term
   always_comb begin
      for (int i = 0; i < NUM_POINTS; i++) begin
         wl[i] = $signed({1'b0, weight[i][WLO_W-1:0]});
         wh[i] = $signed({1'b0, weight[i][WGT_W-1:WLO_W]});
         pl[i] = $signed({1'b0, point[i][HALF_W-1:0]});
         ph[i] = point[i][COORD_W-1:HALF_W];
         ll4_in[i] = PP_W'(wl[i]) * PP_W'(pl[i]);
         lh4_in[i] = PP_W'(wl[i]) * PP_W'(ph[i]);
         hl4_in[i] = PP_W'(wh[i]) * PP_W'(pl[i]);
         hh4_in[i] = PP_W'(wh[i]) * PP_W'(ph[i]);
      end
   end

   // stage 5: sum each kind over the control points
   always_comb begin
      ll5_in = '0;
      lh5_in = '0;
      hl5_in = '0;
      hh5_in = '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
         ll5_in = ll5_in + KS_W'(ll4_ff[i]);
         lh5_in = lh5_in + KS_W'(lh4_ff[i]);
         hl5_in = hl5_in + KS_W'(hl4_ff[i]);
         hh5_in = hh5_in + KS_W'(hh4_ff[i]);
      end
   end

   // stage 6: align the kinds and add half an LSB of the result for rounding
   always_comb begin
      total6_in = (SUM_W'(hh5_ff) <<< (WLO_W + HALF_W))
                + (SUM_W'(hl5_ff) <<< WLO_W)
                + (SUM_W'(lh5_ff) <<< HALF_W)
                + SUM_W'(ll5_ff)
                + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            ll4_ff[i] <= ll4_in[i];
            lh4_ff[i] <= lh4_in[i];
            hl4_ff[i] <= hl4_in[i];
            hh4_ff[i] <= hh4_in[i];
         end
      end
      if (en.s5) begin
         ll5_ff <= ll5_in;
         lh5_ff <= lh5_in;
         hl5_ff <= hl5_in;
         hh5_ff <= hh5_in;
      end
      if (en.s6) begin
         total6_ff <= total6_in;
      end
   end

   assign total = total6_ff;

endmodule

/* hdl/bezier_curve_evaluation.sv */
// Top level of the planar Bezier curve evaluator (Bernstein form).
//
//  group  dir  width  contents
//  req_   in   24     tdata: curve_param[16:0] (t, Q1.16), zero pad above
//  rsp_   out  64     tdata: point_x[31:0], point_y[63:32] (Q16.16)
//  csr_   in   4+32   csr_index selects point0_x .. point3_y, csr_data value
//
//  One request per cycle, unless rsp_ stalls a full pipe, through seven register
//  stages; the last one registers the response on rsp_tdata.
//  Depth set by the split 49x32 weight-by-coordinate multiply and its sums.
//  Every stage carries a valid bit; a stage loads when empty or when the one
//  after it moves, so bubbles close up and req_tready stays high while any
//  stage is free. A stall on rsp_ holds each full stage with no free one after.
//  Reset (synchronous) empties the pipe and clears all control points.
module bezier_curve_evaluation
   import bce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: curve_param[16:0]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // response: point_x[31:0], point_y[63:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // control point writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_data
);

   coord_type [MAX_POINTS-1:0] px_ff, px_in, py_ff, py_in;

   logic [NSTAGE:1] v_ff, v_in, en;
   pipe_en_type     pipe_en;

   wgt_type [NUM_POINTS-1:0] weight;
   logic signed [SUM_W-1:0]  total_x, total_y;
   coord_type                out_x_ff, out_x_in, out_y_ff, out_y_in;

   // ---------------- control point registers ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_POINT0_X: px_in[0] = csr_data;
            REG_POINT0_Y: py_in[0] = csr_data;
            REG_POINT1_X: px_in[1] = csr_data;
            REG_POINT1_Y: py_in[1] = csr_data;
            REG_POINT2_X: px_in[2] = csr_data;
            REG_POINT2_Y: py_in[2] = csr_data;
            REG_POINT3_X: px_in[3] = csr_data;
            REG_POINT3_Y: py_in[3] = csr_data;
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
      end else begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // ---------------- pipeline control ----------------
   // A stage may load when it is empty or its contents move on this cycle.
   always_comb begin
      en[NSTAGE] = !v_ff[NSTAGE] || rsp_tready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
      v_in[1] = en[1] ? req_tvalid : v_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         v_in[k] = en[k] ? v_ff[k - 1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[1];

   always_comb begin
      pipe_en.s1 = en[1];
      pipe_en.s2 = en[2];
      pipe_en.s3 = en[3];
      pipe_en.s4 = en[4];
      pipe_en.s5 = en[5];
      pipe_en.s6 = en[6];
   end

   // ---------------- datapath ----------------
   // stages 1-3: Bernstein weights from t
   bce_weights u_weights (
      .clock       (clock),
      .en          (pipe_en),
      .curve_param (req_tdata[PARAM_W-1:0]),
      .weight      (weight)
   );

   // stages 4-6: weighted sums, one unit per coordinate
   bce_combine u_combine_x (
      .clock  (clock),
      .en     (pipe_en),
      .weight (weight),
      .point  (px_ff[NUM_POINTS-1:0]),
      .total  (total_x)
   );

   bce_combine u_combine_y (
      .clock  (clock),
      .en     (pipe_en),
      .weight (weight),
      .point  (py_ff[NUM_POINTS-1:0]),
      .total  (total_y)
   );

   // stage 7: drop the fraction bits and saturate to 32 bits signed.
   // The bits above the result field must all match the sign, else clip.
   function automatic coord_type sat_round(input logic signed [SUM_W-1:0] tot);
      logic [SUM_W-FRAC_W-COORD_W:0] top;
      coord_type                     r;
      top = tot[SUM_W-1:FRAC_W+COORD_W-1];
      if ((&top) || !(|top)) begin
         r = tot[FRAC_W+COORD_W-1:FRAC_W];
      end else if (tot[SUM_W-1]) begin
         r = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W - 1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      out_x_in = sat_round(total_x);
      out_y_in = sat_round(total_y);
   end

   always_ff @(posedge clock) begin
      if (en[NSTAGE]) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign rsp_tvalid = v_ff[NSTAGE];
   assign rsp_tdata  = {out_y_ff, out_x_ff};

   // ---------------- assertions ----------------
   // A full, stalled pipe must refuse new requests.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_tready |-> !req_tready)
      else $error("request accepted into a full stalled pipe");

   // Any empty stage lets a request in (bubbles collapse).
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !(&v_ff) |-> req_tready)
      else $error("pipe has a bubble but refuses requests");

   // An accepted request occupies stage one next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[1])
      else $error("accepted request lost at stage one");

   // A finished item advancing into the output stage shows up as a response.
   a_exit: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTAGE-1] && en[NSTAGE] |=> rsp_tvalid)
      else $error("item lost entering the output stage");

endmodule

/* verif/tb_bezier_curve_evaluation.sv */
// Self-checking testbench for the planar Bezier curve evaluator.
`timescale 1ns / 100ps

module tb_bezier_curve_evaluation
   import bce_pkg::*;
;

   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 150;
   localparam int HOLD_CYCLES   = 64;    // long rsp_ back-pressure, fills the pipe
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all

   typedef logic signed [127:0] wide_sum_type;

   typedef struct {
      logic [PARAM_W-1:0] t;
      coord_type          x;
      coord_type          y;
   } curve_point_type;

   typedef enum int {RX_STEADY, RX_COIN, RX_EVERY_THIRD} rx_mode_type;

   // Holds the control points as last written and the points still owed by the block.
   class curve_scoreboard;
      coord_type       ctrl_pt [2*MAX_POINTS];
      curve_point_type expected_points [$];
      int              failures;
      int              seen;

      function new();
         foreach (ctrl_pt[i]) ctrl_pt[i] = '0;
         failures = 0;
         seen     = 0;
      endfunction

      function void write_point(logic [CSR_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
         // indexes past the last point register are dropped by the block
         if (idx <= REG_POINT3_Y) ctrl_pt[idx[2:0]] = val;
      endfunction

      // Bernstein sum in exact integers, scaled down by 2^(16*DEGREE),
      // rounded half up, then clipped to 32 bits signed
      function coord_type curve_coord(logic [PARAM_W-1:0] t_in, int axis);
         wide_sum_type t_fix, s_fix, wgt, acc, half;
         int           coef;
         int           shift;
         t_fix = (t_in > PARAM_ONE) ? PARAM_ONE : t_in;
         s_fix = wide_sum_type'(PARAM_ONE) - t_fix;
         shift = HALF_W * DEGREE;
         acc   = '0;
         coef  = 1;
         for (int i = 0; i <= DEGREE; i++) begin
            wgt = wide_sum_type'(coef);
            for (int k = 0; k < i; k++) wgt = wgt * t_fix;
            for (int k = i; k < DEGREE; k++) wgt = wgt * s_fix;
            acc  = acc + wgt * wide_sum_type'(ctrl_pt[2*i + axis]);
            coef = coef * (DEGREE - i) / (i + 1);
         end
         half = wide_sum_type'(1);
         half = half <<< (shift - 1);
         acc  = (acc + half) >>> shift;
         if (acc > wide_sum_type'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
         if (acc < wide_sum_type'(32'sh8000_0000)) return 32'h8000_0000;
         return acc[COORD_W-1:0];
      endfunction

      function void note_request(logic [PARAM_W-1:0] t_in);
         curve_point_type pt;
         pt.t = t_in;
         pt.x = curve_coord(t_in, 0);
         pt.y = curve_coord(t_in, 1);
         expected_points.insert(expected_points.size(), pt);
      endfunction

      function void check_point(coord_type got_x, coord_type got_y);
         curve_point_type pt;
         seen++;
         if (expected_points.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response #%0d with nothing outstanding: (%h,%h)",
                        seen, got_x, got_y);
            return;
         end
         pt = expected_points.pop_front();
         if (got_x !== pt.x || got_y !== pt.y) begin
            failures++;
            if (failures <= 10)
               $display("point mismatch #%0d t=%h: expected (%h,%h) got (%h,%h)",
                        seen, pt.t, pt.x, pt.y, got_x, got_y);
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COORD_W-1:0]     csr_data;

   curve_scoreboard curve_board = new();
   coord_type       staged [2*MAX_POINTS];  // next control point set to load
   bit              hold_requested = 1'b0;
   int              idle_cycles = 0;

   bezier_curve_evaluation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // curve_param[16:0], zero above
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // point_x[31:0], point_y[63:32]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Monitor: every handshake is sampled on the rising edge, before the
   // block's own registers move. Requests feed the predictor, responses
   // are checked in order, register writes update the predictor's copy.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            curve_board.note_request(req_tdata[PARAM_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            curve_board.check_point(rsp_tdata[COORD_W-1:0],
                                    rsp_tdata[RSP_DATA_W-1:COORD_W]);
         if (csr_valid && csr_ready)
            curve_board.write_point(csr_index, csr_data);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
   end

   // Watchdog: a run that stops moving is a failure
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: changes mode after each random span; now and then (and once
   // on request from the stimulus) it holds off long enough that the pipe
   // fills and req_tready drops.
   initial begin
      rx_mode_type mode;
      int          span;
      rsp_tready = 1'b0;
      forever begin
         if (hold_requested || $urandom_range(0, 24) == 0) begin
            hold_requested = 1'b0;
            rsp_tready     = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = rx_mode_type'($urandom_range(RX_STEADY, RX_EVERY_THIRD));
         span = $urandom_range(8, 60);
         for (int k = 0; k < span; k++) begin
            unique case (mode)
               RX_STEADY:      rsp_tready = 1'b1;
               RX_COIN:        rsp_tready = 1'($urandom_range(0, 1));
               RX_EVERY_THIRD: rsp_tready = (k % 3 == 2);
               default:        rsp_tready = 1'b1;
            endcase
            @(negedge clock);
         end
      end
   end

   // Offer one curve parameter, hold it until taken. Returns on the falling
   // edge after acceptance with tvalid still high; the caller either offers
   // the next one or drops tvalid at that same edge.
   task automatic send_request(input logic [PARAM_W-1:0] t);
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_W - PARAM_W){1'b0}}, t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [COORD_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Load all eight coordinates from staged; optionally follow with a write
   // to an index past the last register, which must change nothing.
   task automatic load_points(input bit with_stray);
      for (int r = REG_POINT0_X; r <= REG_POINT3_Y; r++)
         write_csr(CSR_INDEX_W'(r), staged[r]);
      if (with_stray)
         write_csr(CSR_INDEX_W'($urandom_range(REG_POINT3_Y + 1, 2**CSR_INDEX_W - 1)),
                   $urandom());
      csr_valid = 1'b0;
   endtask

   // Stop offering, wait for every owed point, then let the pipe go quiet
   task automatic settle();
      req_tvalid = 1'b0;
      while (curve_board.pending() != 0) @(negedge clock);
      repeat (NSTAGE + 3) @(negedge clock);
   endtask

   // Mostly t in [0,1]; endpoints, clamped values above one and raw
   // 17-bit noise mixed in
   function automatic logic [PARAM_W-1:0] pick_param();
      unique case ($urandom_range(0, 9))
         0: begin
            unique case ($urandom_range(0, 3))
               0:       return '0;
               1:       return 17'd1;
               2:       return PARAM_ONE - 17'd1;
               default: return PARAM_ONE;
            endcase
         end
         1:       return PARAM_W'($urandom_range(PARAM_ONE + 1, 2**PARAM_W - 1));
         2:       return PARAM_W'($urandom_range(0, 2**PARAM_W - 1));
         default: return PARAM_W'($urandom_range(0, PARAM_ONE));
      endcase
   endfunction

   function automatic coord_type pick_coord();
      unique case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         4, 5, 6: return coord_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: return $urandom();
      endcase
   endfunction

   // Bursts of back-to-back requests with random gaps between them
   task automatic send_stream(input int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 30);
         if (burst > left) burst = left;
         repeat (burst) send_request(pick_param());
         left = left - burst;
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Points straight out of reset are all zero
      send_request('0);
      send_request(PARAM_ONE);
      settle();

      // Mixed small points with fractions, plus a write to a bogus index.
      // t sweeps zero, one lsb, half, just under one, one, values past
      // one that must clamp to the last point, and about one third.
      staged = '{32'h0001_0000, 32'hFFFE_0000, 32'h0003_8001, 32'h0004_4000,
                 32'hFFFE_4000, 32'h0000_8000, 32'h0002_0000, 32'hFFFD_0000};
      load_points(1'b1);
      send_request('0);
      send_request(17'd1);
      send_request(17'h0_8000);
      send_request(PARAM_ONE - 17'd1);
      send_request(PARAM_ONE);
      send_request(PARAM_ONE + 17'd1);
      send_request(17'h1_FFFF);
      send_request(17'h0_5555);
      settle();

      // All points at the positive limit: result must stay pinned there
      foreach (staged[i]) staged[i] = 32'h7FFF_FFFF;
      load_points(1'b0);
      send_request('0);
      send_request(17'h0_8000);
      send_request(PARAM_ONE);
      settle();

      // All points at the negative limit
      foreach (staged[i]) staged[i] = 32'h8000_0000;
      load_points(1'b0);
      send_request('0);
      send_request(17'h0_8000);
      send_request(PARAM_ONE);
      settle();

      // Alternating extremes: largest swings in the partial sums
      staged = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
      load_points(1'b0);
      send_request(17'h0_0000);
      send_request(17'h0_4000);
      send_request(17'h0_8000);
      send_request(17'h0_C000);
      settle();

      // Random phases, each with a fresh control point set; the first one
      // also asks the receiver for its long hold-off mid-stream
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         foreach (staged[i]) staged[i] = pick_coord();
         load_points(1'($urandom_range(0, 1)));
         if (phase == 0) hold_requested = 1'b1;
         send_stream(PHASE_ITEMS);
         settle();
      end

      repeat (2 * NSTAGE) @(negedge clock);
      if (curve_board.pending() != 0)
         $display("%0d expected points never arrived", curve_board.pending());
      if (curve_board.failures == 0 && curve_board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
